// File: src/bmpd_pkg.sv
// shared types and constants of the bmp stream pixel decoder
package bmpd_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int PAL_DEPTH  = 256;
	localparam int PAL_AW     = $clog2(PAL_DEPTH);
	localparam int LANES      = 8;

	localparam logic [1:0] KIND_PIX  = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [2:0] ERR_MAGIC  = 3'd0;
	localparam logic [2:0] ERR_INFO   = 3'd1;
	localparam logic [2:0] ERR_PLANES = 3'd2;
	localparam logic [2:0] ERR_BPP    = 3'd3;
	localparam logic [2:0] ERR_COMP   = 3'd4;
	localparam logic [2:0] ERR_INDEX  = 3'd5;
	localparam logic [2:0] ERR_SIZE   = 3'd6;
	localparam logic [2:0] ERR_TRUNC  = 3'd7;

	typedef enum logic [3:0] {
		PH_HDR   = 4'b0001,
		PH_PAL   = 4'b0010,
		PH_PIX   = 4'b0100,
		PH_DRAIN = 4'b1000
	} bmpd_phase_t;

	// work for one accepted byte: pixels first, then an optional event
	typedef struct packed {
		logic [3:0]            npix;
		logic                  direct;
		logic [LANES-1:0][7:0] idx;
		logic [23:0]           rgb;
		logic [7:0]            alpha;
		logic [11:0]           col;
		logic [11:0]           row;
		logic                  has_ev;
		logic [1:0]            ev_kind;
		logic [2:0]            ev_code;
		logic                  has_alpha;
		logic                  top_down;
	} bmpd_job_t;

	typedef struct packed {
		logic              we;
		logic [PAL_AW-1:0] addr;
		logic [1:0]        lane;
		logic [7:0]        data;
	} bmpd_pal_wr_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        use_ram;
		logic [23:0] rgb;
		logic [7:0]  alpha;
		logic [11:0] col;
		logic [11:0] row;
		logic [2:0]  err;
		logic        has_alpha;
		logic        top_down;
		logic        last;
	} bmpd_res_t;

endpackage

// File: src/bmpd_pal_ram.sv
// palette memory, one write port with byte lanes, one registered read port
module bmpd_pal_ram
	import bmpd_pkg::*;
(
	input  logic              clk,
	input  bmpd_pal_wr_t      wr,
	input  logic              rd_en,
	input  logic [PAL_AW-1:0] rd_addr,
	output logic [23:0]       rd_data
);

	logic [23:0] mem [PAL_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr][{wr.lane, 3'b000} +: 8] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: src/bmpd_parse.sv
// header, palette and row parser, turns accepted bytes into jobs of pixels and events
module bmpd_parse
	import bmpd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [7:0]   data_byte,
	input  logic         final_byte,
	input  logic         job_ready,
	input  logic         pal_idle,
	output logic         job_valid,
	output bmpd_job_t    job,
	output bmpd_pal_wr_t pal_wr
);

	localparam logic [5:0] OFS_MAGIC  = 6'd1;
	localparam logic [5:0] OFS_INFO   = 6'd17;
	localparam logic [5:0] OFS_WIDTH  = 6'd21;
	localparam logic [5:0] OFS_HEIGHT = 6'd25;
	localparam logic [5:0] OFS_PLANES = 6'd27;
	localparam logic [5:0] OFS_BPP    = 6'd29;
	localparam logic [5:0] OFS_COMP   = 6'd33;
	localparam logic [5:0] OFS_CLRS   = 6'd49;
	localparam logic [5:0] OFS_LAST   = 6'd53;

	bmpd_phase_t phase_q, phase_d;
	logic [5:0]  hcnt_q, hcnt_d;
	logic [31:0] hword_q, hword_d;
	logic [5:0]  bpp_q, bpp_d;
	logic [12:0] width_q, width_d;
	logic [12:0] height_q, height_d;
	logic        flip_q, flip_d;
	logic [31:0] pcount_q, pcount_d;
	logic [33:0] pread_q, pread_d;
	logic [12:0] rowc_q, rowc_d;
	logic [14:0] rbyte_q, rbyte_d;
	logic [12:0] pcol_q, pcol_d;
	logic [23:0] pbytes_q, pbytes_d;
	logic [1:0]  sub_q, sub_d;
	logic [3:0]  fault_q, fault_d;

	logic        acc;
	logic [31:0] hword_new;
	logic [15:0] w16;
	logic [31:0] hmag;
	logic [14:0] w15;
	logic [14:0] row_raw;
	logic [14:0] row_len;
	logic [14:0] rb1;
	logic [12:0] rowc1;
	logic [33:0] pread1;
	logic [LANES-1:0][7:0] lane_idx;
	logic [LANES-1:0]      lane_in;
	logic [LANES-1:0]      lane_bad;
	logic [3:0]  pal_n;
	logic        pal_bad;
	logic        fset;
	logic [2:0]  fcode;
	logic [3:0]  fm1;
	logic [31:0] pc_fin;
	logic        done;
	logic        emit;
	logic        row_step;

	assign acc       = in_valid && !in_stall;
	assign in_stall  = !job_ready || (phase_q == PH_PAL && !pal_idle);
	assign hword_new = {data_byte, hword_q[31:8]};
	assign w16       = hword_new[31:16];
	assign hmag      = hword_new[31] ? (~hword_new + 32'd1) : hword_new;
	assign w15       = {2'b00, width_q};
	assign rb1       = rbyte_q + 15'd1;
	assign rowc1     = rowc_q + 13'd1;
	assign pread1    = pread_q + 34'd1;
	assign row_len   = (row_raw + 15'd3) & ~15'd3;

	always_comb begin
		case (bpp_q)
			6'd1:    row_raw = (w15 + 15'd7) >> 3;
			6'd4:    row_raw = (w15 + 15'd1) >> 1;
			6'd8:    row_raw = w15;
			6'd24:   row_raw = (w15 << 1) + w15;
			default: row_raw = w15 << 2;
		endcase
	end

	// palette lanes of one byte
	always_comb begin
		logic stop;
		stop    = 1'b0;
		pal_n   = 4'd0;
		pal_bad = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			if (bpp_q == 6'd1) begin
				lane_idx[i] = {7'd0, data_byte[LANES-1-i]};
			end else if (bpp_q == 6'd4) begin
				lane_idx[i] = (i == 0) ? {4'd0, data_byte[7:4]} : {4'd0, data_byte[3:0]};
			end else begin
				lane_idx[i] = data_byte;
			end
			lane_in[i] = ((bpp_q == 6'd1) || (bpp_q == 6'd4 && i < 2) || i == 0) &&
				((14'(pcol_q) + 14'(i)) < {1'b0, width_q});
			lane_bad[i] = (pcount_q[31:8] == 24'd0) && (pcount_q[7:0] <= lane_idx[i]);
			if (!stop) begin
				if (!lane_in[i]) begin
					stop = 1'b1;
				end else if (lane_bad[i]) begin
					stop    = 1'b1;
					pal_bad = 1'b1;
				end else begin
					pal_n = 4'(i + 1);
				end
			end
		end
	end

	always_comb begin
		phase_d  = phase_q;
		hcnt_d   = hcnt_q;
		hword_d  = hword_q;
		bpp_d    = bpp_q;
		width_d  = width_q;
		height_d = height_q;
		flip_d   = flip_q;
		pcount_d = pcount_q;
		pread_d  = pread_q;
		rowc_d   = rowc_q;
		rbyte_d  = rbyte_q;
		pcol_d   = pcol_q;
		pbytes_d = pbytes_q;
		sub_d    = sub_q;
		fault_d  = fault_q;
		fset     = 1'b0;
		fcode    = ERR_MAGIC;
		fm1      = 4'd0;
		pc_fin   = 32'd0;
		done     = 1'b0;
		emit     = 1'b0;
		row_step = 1'b0;
		pal_wr   = '0;

		job           = '0;
		job.idx       = lane_idx;
		job.col       = pcol_q[11:0];
		job.row       = rowc_q[11:0];
		job.has_alpha = (bpp_q == 6'd32);
		job.top_down  = flip_q;

		if (acc) begin
			case (phase_q)
				PH_HDR: begin
					hword_d = hword_new;
					hcnt_d  = hcnt_q + 6'd1;
					case (hcnt_q)
						OFS_MAGIC: begin
							if (w16 != 16'h4D42) begin
								fset  = 1'b1;
								fcode = ERR_MAGIC;
							end
						end
						OFS_INFO: begin
							if (hword_new != 32'd40) begin
								fset  = 1'b1;
								fcode = ERR_INFO;
							end
						end
						OFS_WIDTH: begin
							if (hword_new > 32'(MAX_WIDTH)) begin
								fset  = 1'b1;
								fcode = ERR_SIZE;
							end else begin
								width_d = hword_new[12:0];
							end
						end
						OFS_HEIGHT: begin
							if (hword_new[31]) begin
								flip_d = 1'b1;
							end
							if (hmag > 32'(MAX_HEIGHT)) begin
								fset  = 1'b1;
								fcode = ERR_SIZE;
							end else begin
								height_d = hmag[12:0];
							end
						end
						OFS_PLANES: begin
							if (w16 != 16'd1) begin
								fset  = 1'b1;
								fcode = ERR_PLANES;
							end
						end
						OFS_BPP: begin
							if (w16 == 16'd1 || w16 == 16'd4 || w16 == 16'd8 ||
								w16 == 16'd24 || w16 == 16'd32) begin
								bpp_d = w16[5:0];
							end else begin
								fset  = 1'b1;
								fcode = ERR_BPP;
							end
						end
						OFS_COMP: begin
							if (hword_new != 32'd0 && hword_new != 32'd3) begin
								fset  = 1'b1;
								fcode = ERR_COMP;
							end
						end
						OFS_CLRS: begin
							pcount_d = hword_new;
						end
						default: begin
						end
					endcase
					if (fset && (fault_q == 4'd0 || ({1'b0, fcode} + 4'd1) < fault_q)) begin
						fault_d = {1'b0, fcode} + 4'd1;
					end
					if (hcnt_q == OFS_LAST) begin
						if (fault_d != 4'd0) begin
							fm1         = fault_d - 4'd1;
							job.has_ev  = 1'b1;
							job.ev_kind = KIND_ERR;
							job.ev_code = fm1[2:0];
							done        = 1'b1;
						end else begin
							if (bpp_q <= 6'd8) begin
								pc_fin = (pcount_q == 32'd0) ? (32'd1 << bpp_q) : pcount_q;
							end
							pcount_d = pc_fin;
							pread_d  = 34'd0;
							if (pc_fin != 32'd0) begin
								phase_d = PH_PAL;
							end else begin
								phase_d = PH_PIX;
								if (width_q == 13'd0 || height_q == 13'd0) begin
									job.has_ev  = 1'b1;
									job.ev_kind = KIND_DONE;
									done        = 1'b1;
								end
							end
						end
					end
				end
				PH_PAL: begin
					if (pread_q[33:10] == 24'd0 && pread_q[1:0] != 2'd3) begin
						pal_wr.we   = 1'b1;
						pal_wr.addr = pread_q[9:2];
						pal_wr.lane = pread_q[1:0];
						pal_wr.data = data_byte;
					end
					pread_d = pread1;
					if (pread1 == {pcount_q, 2'b00}) begin
						phase_d = PH_PIX;
						if (width_q == 13'd0 || height_q == 13'd0) begin
							job.has_ev  = 1'b1;
							job.ev_kind = KIND_DONE;
							done        = 1'b1;
						end
					end
				end
				PH_PIX: begin
					if (bpp_q <= 6'd8) begin
						job.npix = pal_n;
						if (pal_bad) begin
							job.has_ev  = 1'b1;
							job.ev_kind = KIND_ERR;
							job.ev_code = ERR_INDEX;
							done        = 1'b1;
						end else begin
							pcol_d   = pcol_q + 13'(pal_n);
							row_step = 1'b1;
						end
					end else begin
						row_step = 1'b1;
						if (rbyte_q < row_raw) begin
							emit = (sub_q == 2'd2 && bpp_q == 6'd24) || sub_q == 2'd3;
							case (sub_q)
								2'd0:    pbytes_d = {16'd0, data_byte};
								2'd1:    pbytes_d[15:8] = data_byte;
								2'd2:    pbytes_d[23:16] = data_byte;
								default: pbytes_d = pbytes_q;
							endcase
							if (emit) begin
								job.npix   = 4'd1;
								job.direct = 1'b1;
								job.rgb    = (sub_q == 2'd3) ? pbytes_q :
									{data_byte, pbytes_q[15:0]};
								job.alpha  = (sub_q == 2'd3) ? data_byte : 8'd0;
								pcol_d     = pcol_q + 13'd1;
								pbytes_d   = 24'd0;
								sub_d      = 2'd0;
							end else begin
								sub_d = sub_q + 2'd1;
							end
						end
					end
					if (row_step) begin
						if (rb1 >= row_len) begin
							rbyte_d = 15'd0;
							pcol_d  = 13'd0;
							sub_d   = 2'd0;
							rowc_d  = rowc1;
							if (rowc1 >= height_q) begin
								job.has_ev  = 1'b1;
								job.ev_kind = KIND_DONE;
								done        = 1'b1;
							end
						end else begin
							rbyte_d = rb1;
						end
					end
				end
				default: begin
				end
			endcase

			if (phase_q != PH_DRAIN && !done && final_byte) begin
				job.has_ev  = 1'b1;
				job.ev_kind = KIND_ERR;
				job.ev_code = ERR_TRUNC;
				done        = 1'b1;
			end
			if (done && !final_byte) begin
				phase_d = PH_DRAIN;
			end
			// new file starts after the closing byte
			if (final_byte && (done || phase_q == PH_DRAIN)) begin
				phase_d  = PH_HDR;
				hcnt_d   = 6'd0;
				hword_d  = 32'd0;
				bpp_d    = 6'd0;
				width_d  = 13'd0;
				height_d = 13'd0;
				flip_d   = 1'b0;
				pcount_d = 32'd0;
				pread_d  = 34'd0;
				rowc_d   = 13'd0;
				rbyte_d  = 15'd0;
				pcol_d   = 13'd0;
				pbytes_d = 24'd0;
				sub_d    = 2'd0;
				fault_d  = 4'd0;
			end
		end
	end

	assign job_valid = acc && (job.npix != 4'd0 || job.has_ev);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			hcnt_q   <= 6'd0;
			hword_q  <= 32'd0;
			bpp_q    <= 6'd0;
			width_q  <= 13'd0;
			height_q <= 13'd0;
			flip_q   <= 1'b0;
			pcount_q <= 32'd0;
			pread_q  <= 34'd0;
			rowc_q   <= 13'd0;
			rbyte_q  <= 15'd0;
			pcol_q   <= 13'd0;
			pbytes_q <= 24'd0;
			sub_q    <= 2'd0;
			fault_q  <= 4'd0;
		end else begin
			phase_q  <= phase_d;
			hcnt_q   <= hcnt_d;
			hword_q  <= hword_d;
			bpp_q    <= bpp_d;
			width_q  <= width_d;
			height_q <= height_d;
			flip_q   <= flip_d;
			pcount_q <= pcount_d;
			pread_q  <= pread_d;
			rowc_q   <= rowc_d;
			rbyte_q  <= rbyte_d;
			pcol_q   <= pcol_d;
			pbytes_q <= pbytes_d;
			sub_q    <= sub_d;
			fault_q  <= fault_d;
		end
	end

endmodule

// File: src/bmpd_expand.sv
// job expander: palette lookup stage and output register
module bmpd_expand
	import bmpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  bmpd_job_t         job,
	output logic              job_ready,
	output logic              idle,
	output logic              rd_en,
	output logic [PAL_AW-1:0] rd_addr,
	input  logic [23:0]       rd_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic [7:0]        alpha,
	output logic              has_alpha,
	output logic [11:0]       column,
	output logic [11:0]       row,
	output logic              top_down,
	output logic [2:0]        error_code,
	output logic              last_of_item
);

	logic      job_v_q;
	bmpd_job_t job_q;
	logic [3:0] i_q;
	logic      s1_v_q;
	bmpd_res_t s1_q;
	bmpd_res_t s1_d;
	logic      s2_v_q;
	bmpd_res_t s2_q;
	bmpd_res_t s2_d;

	logic [3:0] total;
	logic       last_el;
	logic       is_pix;
	logic       s1_move;
	logic       s1_free;
	logic       issue;

	assign total     = job_q.npix + {3'd0, job_q.has_ev};
	assign last_el   = (i_q == total - 4'd1);
	assign is_pix    = (i_q < job_q.npix);
	assign s1_move   = s1_v_q && (!s2_v_q || !out_stall);
	assign s1_free   = !s1_v_q || s1_move;
	assign issue     = job_v_q && s1_free;
	assign job_ready = !job_v_q || (issue && last_el);
	assign idle      = !job_v_q && !s1_v_q;
	assign rd_en     = issue && is_pix && !job_q.direct;
	assign rd_addr   = job_q.idx[i_q[2:0]];

	always_comb begin
		s1_d      = '0;
		s1_d.last = last_el;
		if (is_pix) begin
			s1_d.kind      = KIND_PIX;
			s1_d.use_ram   = !job_q.direct;
			s1_d.rgb       = job_q.rgb;
			s1_d.alpha     = job_q.alpha;
			s1_d.col       = job_q.col + {8'd0, i_q};
			s1_d.row       = job_q.row;
			s1_d.has_alpha = job_q.has_alpha;
			s1_d.top_down  = job_q.top_down;
		end else begin
			s1_d.kind      = job_q.ev_kind;
			s1_d.err       = job_q.ev_code;
			s1_d.has_alpha = (job_q.ev_kind != KIND_ERR) && job_q.has_alpha;
			s1_d.top_down  = (job_q.ev_kind != KIND_ERR) && job_q.top_down;
		end
	end

	always_comb begin
		s2_d     = s1_q;
		s2_d.rgb = s1_q.use_ram ? rd_data : s1_q.rgb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q <= 1'b0;
			i_q     <= 4'd0;
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
		end else begin
			if (job_valid && job_ready) begin
				job_v_q <= 1'b1;
				i_q     <= 4'd0;
			end else if (issue) begin
				if (last_el) begin
					job_v_q <= 1'b0;
				end else begin
					i_q <= i_q + 4'd1;
				end
			end
			if (issue) begin
				s1_v_q <= 1'b1;
			end else if (s1_move) begin
				s1_v_q <= 1'b0;
			end
			if (s1_move) begin
				s2_v_q <= 1'b1;
			end else if (!out_stall) begin
				s2_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_q <= job;
		end
		if (issue) begin
			s1_q <= s1_d;
		end
		if (s1_move) begin
			s2_q <= s2_d;
		end
	end

	assign out_valid    = s2_v_q;
	assign kind         = s2_q.kind;
	assign red          = s2_q.rgb[23:16];
	assign green        = s2_q.rgb[15:8];
	assign blue         = s2_q.rgb[7:0];
	assign alpha        = s2_q.alpha;
	assign has_alpha    = s2_q.has_alpha;
	assign column       = s2_q.col;
	assign row          = s2_q.row;
	assign top_down     = s2_q.top_down;
	assign error_code   = s2_q.err;
	assign last_of_item = s2_q.last;

`ifndef SYNTH
	a_index_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_v_q |-> (i_q < total))
		else $error("element index past end of job");
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q |-> (kind == KIND_PIX || kind == KIND_DONE || kind == KIND_ERR))
		else $error("illegal result kind");
	a_event_no_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && s1_q.kind != KIND_PIX) |-> !s1_q.use_ram)
		else $error("event result tied to palette read");
	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job_ready) |=> (total != 4'd0))
		else $error("empty job loaded");
`endif

endmodule

// File: src/bmp_stream_pixel_decoder.sv
// top level of the streaming bmp pixel decoder
//
// channel   direction  handshake           payload
// input     in         in_valid/in_stall   data_byte, final_byte
// output    out        out_valid/out_stall kind, red, green, blue, alpha, has_alpha,
//                                          column, row, top_down, error_code, last_of_item
//
// one byte a cycle while not stalled; a byte giving several results holds input until the
// expander has issued them all (up to 9 results in 1-bit mode), set by the single-port palette read in the expander
// palette bytes wait until pending palette lookups are done
// a result passes the job register, the lookup register and the output register after its byte is taken
// async reset clears all control state; palette memory is not cleared
module bmp_stream_pixel_decoder
	import bmpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        has_alpha,
	output logic [11:0] column,
	output logic [11:0] row,
	output logic        top_down,
	output logic [2:0]  error_code,
	output logic        last_of_item
);

	logic              job_valid;
	bmpd_job_t         job;
	logic              job_ready;
	logic              pal_idle;
	bmpd_pal_wr_t      pal_wr;
	logic              rd_en;
	logic [PAL_AW-1:0] rd_addr;
	logic [23:0]       rd_data;

	bmpd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.job_ready  (job_ready),
		.pal_idle   (pal_idle),
		.job_valid  (job_valid),
		.job        (job),
		.pal_wr     (pal_wr)
	);

	bmpd_pal_ram u_pal_ram (
		.clk     (clk),
		.wr      (pal_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bmpd_expand u_expand (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.job_ready    (job_ready),
		.idle         (pal_idle),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.has_alpha    (has_alpha),
		.column       (column),
		.row          (row),
		.top_down     (top_down),
		.error_code   (error_code),
		.last_of_item (last_of_item)
	);

endmodule

// File: bench/bmp_stream_pixel_decoder_check.sv
// checker for the bmp stream pixel decoder: predicts decoded pixels and compares results
`timescale 1ns / 100ps
module bmp_stream_pixel_decoder_check
	import bmpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	input  logic        has_alpha,
	input  logic [11:0] column,
	input  logic [11:0] row,
	input  logic        top_down,
	input  logic [2:0]  error_code,
	input  logic        last_of_item,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] rgb;
		logic [7:0]  alpha;
		logic        has_alpha;
		logic [11:0] col;
		logic [11:0] row;
		logic        top_down;
		logic [2:0]  err;
		logic        last;
	} pix_res_t;

	typedef enum int {ST_HDR, ST_PAL, ST_PIX, ST_DRAIN} dec_state_t;

	pix_res_t    expected_pixels[$];
	dec_state_t  st;
	int unsigned hdr_cnt, hword, bpp, wid, hgt, flip, pal_cnt, pix_col, row_cnt, row_bytes;
	int unsigned pix_acc, fault;
	longint unsigned pal_rd;
	logic [23:0] palette [PAL_DEPTH];
	int          nres;

	assign pending = expected_pixels.size();

	function automatic void new_file();
		st = ST_HDR; hdr_cnt = 0; hword = 0; bpp = 0; wid = 0; hgt = 0; flip = 0;
		pal_cnt = 0; pal_rd = 0; row_cnt = 0; row_bytes = 0; pix_col = 0; pix_acc = 0;
		fault = 0;
	endfunction

	function automatic void push_res(logic [1:0] k, logic [23:0] rgb, logic [7:0] a,
		int unsigned c, int unsigned r, logic [2:0] e);
		pix_res_t x;
		logic img;
		img = (k != KIND_ERR);
		x.kind = k; x.rgb = rgb; x.alpha = a;
		x.has_alpha = img && bpp == 32;
		x.col = c[11:0]; x.row = r[11:0];
		x.top_down = img ? flip[0] : 1'b0;
		x.err = e; x.last = 0;
		expected_pixels.push_back(x);
		nres++;
	endfunction

	function automatic void add_fault(int unsigned code);
		if (fault == 0 || code + 1 < fault) fault = code + 1;
	endfunction

	function automatic int unsigned padded_row();
		int unsigned n;
		case (bpp)
			1: n = (wid + 7) / 8;
			4: n = (wid + 1) / 2;
			8: n = wid;
			24: n = 3 * wid;
			default: n = 4 * wid;
		endcase
		return (n + 3) & ~32'd3;
	endfunction

	function automatic bit start_pixels();
		st = ST_PIX; row_cnt = 0; row_bytes = 0; pix_col = 0; pix_acc = 0;
		if (padded_row() == 0 || hgt == 0) begin
			push_res(KIND_DONE, 0, 0, 0, 0, 0);
			return 1;
		end
		return 0;
	endfunction

	function automatic bit do_header(logic [7:0] b);
		int unsigned v, w16, mag;
		hword = (hword >> 8) | (32'(b) << 24);
		v = hword; w16 = v >> 16;
		case (hdr_cnt)
			1: if (w16 != 16'h4D42) add_fault(ERR_MAGIC);
			17: if (v != 40) add_fault(ERR_INFO);
			21: if (v > MAX_WIDTH) add_fault(ERR_SIZE); else wid = v;
			25: begin
				mag = v;
				if (v[31]) begin
					flip = 1; mag = -v;
				end
				if (mag > MAX_HEIGHT) add_fault(ERR_SIZE); else hgt = mag;
			end
			27: if (w16 != 1) add_fault(ERR_PLANES);
			29: if (w16 == 1 || w16 == 4 || w16 == 8 || w16 == 24 || w16 == 32) bpp = w16;
				else add_fault(ERR_BPP);
			33: if (v != 0 && v != 3) add_fault(ERR_COMP);
			49: pal_cnt = v;
			default: ;
		endcase
		if (hdr_cnt < 53) begin
			hdr_cnt++;
			return 0;
		end
		if (fault != 0) begin
			push_res(KIND_ERR, 0, 0, 0, 0, 3'(fault - 1));
			return 1;
		end
		if (bpp <= 8) begin
			if (pal_cnt == 0) pal_cnt = 1 << bpp;
		end else begin
			pal_cnt = 0;
		end
		pal_rd = 0;
		if (pal_cnt != 0) begin
			st = ST_PAL;
			return 0;
		end
		return start_pixels();
	endfunction

	function automatic bit do_palette(logic [7:0] b);
		longint unsigned e;
		int unsigned comp;
		e = pal_rd >> 2; comp = pal_rd & 3;
		if (e < PAL_DEPTH && comp < 3) palette[e][8*comp +: 8] = b;
		pal_rd++;
		if (pal_rd == longint'(pal_cnt) * 4) return start_pixels();
		return 0;
	endfunction

	function automatic bit do_pixel(logic [7:0] b);
		int unsigned ppb, idx, bpb, sub;
		if (bpp <= 8) begin
			ppb = 8 / bpp;
			for (int i = 0; i < ppb && pix_col < wid; i++) begin
				if (bpp == 1) idx = (b >> (7 - i)) & 1;
				else if (bpp == 4) idx = (i == 0) ? (b >> 4) : (b & 8'h0f);
				else idx = b;
				if (idx >= pal_cnt) begin
					push_res(KIND_ERR, 0, 0, 0, 0, ERR_INDEX);
					return 1;
				end
				push_res(KIND_PIX, palette[idx[7:0]], 0, pix_col, row_cnt, 0);
				pix_col++;
			end
		end else begin
			bpb = bpp / 8;
			if (row_bytes < bpb * wid) begin
				sub = row_bytes % bpb;
				if (sub == 0) pix_acc = b;
				else if (sub < 3) pix_acc |= 32'(b) << (8 * sub);
				if ((sub == 2 && bpb == 3) || sub == 3) begin
					push_res(KIND_PIX, pix_acc[23:0], sub == 3 ? b : 8'd0, pix_col, row_cnt, 0);
					pix_col++;
					pix_acc = 0;
				end
			end
		end
		row_bytes++;
		if (row_bytes >= padded_row()) begin
			row_bytes = 0; pix_col = 0; row_cnt++;
			if (row_cnt >= hgt) begin
				push_res(KIND_DONE, 0, 0, 0, 0, 0);
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic void predict_byte(logic [7:0] b, logic fin);
		bit done;
		done = 0; nres = 0;
		case (st)
			ST_HDR: done = do_header(b);
			ST_PAL: done = do_palette(b);
			ST_PIX: done = do_pixel(b);
			default: begin
				if (fin) new_file();
				return;
			end
		endcase
		if (!done && fin) begin
			push_res(KIND_ERR, 0, 0, 0, 0, ERR_TRUNC);
			done = 1;
		end
		if (done) begin
			if (fin) new_file();
			else st = ST_DRAIN;
		end
		if (nres > 0) expected_pixels[$].last = 1;
	endfunction

	pix_res_t got, want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_file();
			expected_pixels.delete();
			fail_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{kind, {red, green, blue}, alpha, has_alpha, column, row, top_down,
					error_code, last_of_item};
				if (expected_pixels.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %p", got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (got !== want) begin
						if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) predict_byte(data_byte, final_byte);
		end
	end

endmodule

// File: bench/bmp_stream_pixel_decoder_test.sv
// stimulus and verdict for the bmp stream pixel decoder
`timescale 1ns / 100ps
module bmp_stream_pixel_decoder_test;
	import bmpd_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [7:0]  data_byte = 0;
	logic        final_byte = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  kind;
	logic [7:0]  red, green, blue, alpha;
	logic        has_alpha, top_down, last_of_item;
	logic [11:0] column, row;
	logic [2:0]  error_code;
	int          fail_count, pending;
	int          send_idle = 0, recv_stall = 0;
	bit          hold_off = 0;
	int          quiet = 0;
	int          sent = 0;

	always #1 clk = ~clk;

	bmp_stream_pixel_decoder i_dut (.*);

	bmp_stream_pixel_decoder_check i_check (.*);

	// watchdog on cycles with no transfer in either direction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) out_stall <= hold_off || ($urandom_range(99) < recv_stall);

	task automatic send_byte(logic [7:0] b, logic fin);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; data_byte <= b; final_byte <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_le(int unsigned v, int n);
		for (int i = 0; i < n; i++) send_byte(8'(v >> (8 * i)), 0);
	endtask

	// whole file; bad selects a header fault, trunc cuts pixel data short
	task automatic send_file(int unsigned bits, int unsigned w, int signed h,
		int unsigned clr, int bad, bit trunc, bit bad_idx);
		int unsigned rowlen, ncol, npix;
		send_byte(bad == 0 ? 8'h41 : 8'h42, 0);
		send_byte(8'h4D, 0);
		send_le($urandom, 4); send_le($urandom, 4); send_le($urandom, 4);
		send_le(bad == 1 ? 41 : 40, 4);
		send_le(bad == 6 ? MAX_WIDTH + 1 : w, 4);
		send_le(h, 4);
		send_le(bad == 2 ? 2 : 1, 2);
		send_le(bad == 3 ? 16 : bits, 2);
		send_le(bad == 4 ? 1 : ($urandom_range(1) ? 3 : 0), 4);
		send_le($urandom, 4); send_le($urandom, 4); send_le($urandom, 4);
		send_le(clr, 4); send_le($urandom, 3);
		if (bad >= 0) begin
			send_byte($urandom, 1);
			return;
		end
		send_byte($urandom, 0);
		ncol = (bits <= 8) ? (clr == 0 ? (1 << bits) : clr) : 0;
		for (int i = 0; i < ncol * 4; i++) send_byte($urandom, 0);
		case (bits)
			1: rowlen = (w + 7) / 8;
			4: rowlen = (w + 1) / 2;
			8: rowlen = w;
			24: rowlen = 3 * w;
			default: rowlen = 4 * w;
		endcase
		rowlen = (rowlen + 3) & ~32'd3;
		npix = rowlen * (h < 0 ? -h : h);
		if (trunc && npix > 1) npix = $urandom_range(npix - 1, 1);
		for (int i = 0; i < npix; i++) begin
			logic [7:0] b;
			b = $urandom;
			if (bits == 8 && !bad_idx && ncol < 256) b = $urandom_range(ncol - 1);
			if (bits == 4 && !bad_idx && ncol < 16)
				b = {4'($urandom_range(ncol - 1)), 4'($urandom_range(ncol - 1))};
			send_byte(b, trunc && i == npix - 1);
		end
		if (!trunc) send_byte($urandom, 1);
	endtask

	task automatic random_file();
		int unsigned bits;
		int sel;
		sel = $urandom_range(15);
		case ($urandom_range(4))
			0: bits = 1;
			1: bits = 4;
			2: bits = 8;
			3: bits = 24;
			default: bits = 32;
		endcase
		if (sel == 0) send_file(bits, 2, 1, 0, $urandom_range(6), 0, 0);
		else if (sel == 1) begin
			for (int i = 0; i < $urandom_range(8, 1); i++) send_byte($urandom, $urandom_range(1));
			send_byte($urandom, 1);
		end else
			send_file(bits, $urandom_range(5), ($urandom_range(1) ? -1 : 1) * $urandom_range(3),
				bits == 8 ? $urandom_range(4, 1) : (bits == 4 ? $urandom_range(3) : 0),
				-1, sel == 2, sel == 3);
	endtask

	task automatic wait_empty();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_file(8, 1, 1, 0, 0, 0, 0);
		send_file(8, 1, 1, 0, 4, 0, 0);
		send_file(1, 9, -2, 0, -1, 0, 0);
		send_byte(8'hff, 1);
		wait_empty();
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 65 : 28) : 0;
			recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 65 : 28) : 0;
			if (ph == 2) begin
				hold_off = 1;
				fork
					begin
						repeat (300) @(negedge clk);
						hold_off = 0;
					end
				join_none
				send_file(24, 3, 2, 0, -1, 0, 0);
			end
			while (sent < 180 + (ph + 1) * 50) random_file();
			wait_empty();
		end
		send_idle = 0; recv_stall = 0;
		wait_empty();
		repeat (20) @(negedge clk);
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
src/bmpd_pkg.sv
src/bmpd_pal_ram.sv
src/bmpd_parse.sv
src/bmpd_expand.sv
src/bmp_stream_pixel_decoder.sv
bench/bmp_stream_pixel_decoder_check.sv
bench/bmp_stream_pixel_decoder_test.sv
